// ----- rtl/dda_line_rasterizer_unit_defines.svh -----
// Assertion macros used by the rasterizer top level.
`ifndef DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DDA_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dlr_pkg.sv -----
// Shared constants and types of the line rasterizer.
package dlr_pkg;

  localparam int COORD_BITS      = 10;
  localparam int FRAC_BITS       = 16;
  localparam int ACC_BITS        = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS       = FRAC_BITS + 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } out_t;

  // Command handed from the front to the back through the queue.
  typedef struct packed {
    op_t                         kind;
    logic signed [STEP_BITS-1:0] x_step;
    logic signed [STEP_BITS-1:0] y_step;
    logic signed [ACC_BITS-1:0]  x_acc;
    logic signed [ACC_BITS-1:0]  y_acc;
    logic [COORD_BITS-1:0]       len;
  } cmd_t;

endpackage

// ----- rtl/dlr_front.sv -----
// Front end: accepts requests, sets up loads with a restoring divider.
module dlr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dlr_pkg::in_t  in_data,
  output logic          q_push,
  output dlr_pkg::cmd_t q_push_data,
  input  logic          q_full
);
  import dlr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int A     = ACC_BITS;
  localparam int S     = STEP_BITS;
  localparam int CNT_W = $clog2(F + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(F);
  localparam logic [A-1:0] HALF = {{(C + 1){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } st_t;

  st_t              state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [C-1:0]     x_start_r, y_start_r, len_r;
  logic             x_neg_r, y_neg_r, x_nz_r, y_nz_r;
  logic [C:0]       rem_x_r, rem_y_r;
  logic [F:0]       q_x_r, q_y_r;

  logic             accept;
  logic signed [C:0] dx, dy;
  logic [C-1:0]     adx, ady, len_in;
  logic             cmp_x, cmp_y;
  logic [C:0]       rx, ry;
  logic signed [S-1:0] x_step, y_step;
  logic signed [A-1:0] x_base, y_base, x_acc, y_acc;
  cmd_t             load_cmd, step_cmd;

  assign in_stall = (state_r != ST_IDLE) || q_full;
  assign accept   = in_valid && !in_stall;

  assign dx     = $signed({1'b0, in_data.x_end}) - $signed({1'b0, in_data.x_start});
  assign dy     = $signed({1'b0, in_data.y_end}) - $signed({1'b0, in_data.y_start});
  assign adx    = dx[C] ? C'(-dx) : dx[C-1:0];
  assign ady    = dy[C] ? C'(-dy) : dy[C-1:0];
  assign len_in = (adx >= ady) ? adx : ady;

  // One quotient bit per cycle for each axis.
  assign cmp_x = rem_x_r >= {1'b0, len_r};
  assign cmp_y = rem_y_r >= {1'b0, len_r};
  assign rx    = cmp_x ? rem_x_r - {1'b0, len_r} : rem_x_r;
  assign ry    = cmp_y ? rem_y_r - {1'b0, len_r} : rem_y_r;

  always_comb begin
    x_step = '0;
    y_step = '0;
    if (len_r != '0) begin
      x_step = x_neg_r ? -$signed({1'b0, q_x_r}) : $signed({1'b0, q_x_r});
      y_step = y_neg_r ? -$signed({1'b0, q_y_r}) : $signed({1'b0, q_y_r});
    end
  end

  assign x_base = $signed({1'b0, x_start_r, {F{1'b0}}});
  assign y_base = $signed({1'b0, y_start_r, {F{1'b0}}});

  always_comb begin
    x_acc = x_base;
    y_acc = y_base;
    if (x_nz_r) x_acc = x_neg_r ? x_base - $signed(HALF) : x_base + $signed(HALF);
    if (y_nz_r) y_acc = y_neg_r ? y_base - $signed(HALF) : y_base + $signed(HALF);
  end

  always_comb begin
    load_cmd        = '0;
    load_cmd.kind   = OP_LOAD;
    load_cmd.x_step = x_step;
    load_cmd.y_step = y_step;
    load_cmd.x_acc  = x_acc;
    load_cmd.y_acc  = y_acc;
    load_cmd.len    = len_r;
    step_cmd        = '0;
    step_cmd.kind   = OP_STEP;
  end

  assign q_push      = (accept && in_data.opcode == OP_STEP) ||
                       (state_r == ST_PUSH && !q_full);
  assign q_push_data = (state_r == ST_PUSH) ? load_cmd : step_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_data.opcode == OP_LOAD) begin
            x_start_r <= in_data.x_start;
            y_start_r <= in_data.y_start;
            x_neg_r   <= dx[C];
            y_neg_r   <= dy[C];
            x_nz_r    <= dx != '0;
            y_nz_r    <= dy != '0;
            len_r     <= len_in;
            rem_x_r   <= {1'b0, adx};
            rem_y_r   <= {1'b0, ady};
            cnt_r     <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_x_r <= {rx[C-1:0], 1'b0};
          rem_y_r <= {ry[C-1:0], 1'b0};
          q_x_r   <= {q_x_r[F-1:0], cmp_x};
          q_y_r   <= {q_y_r[F-1:0], cmp_y};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == LAST_CNT) state_r <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!q_full) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/dlr_cmd_queue.sv -----
// Short in-order command queue between the front and back ends.
module dlr_cmd_queue #(
  parameter int DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dlr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dlr_pkg::cmd_t pop_data,
  output logic          empty
);
  import dlr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = cnt_r == FULL_CNT;
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- rtl/dlr_back.sv -----
// Back end: holds the active line, steps the accumulators, drives results.
module dlr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dlr_pkg::cmd_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output dlr_pkg::out_t out_data
);
  import dlr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int A = ACC_BITS;

  logic signed [A-1:0]         x_acc_r, y_acc_r;
  logic signed [STEP_BITS-1:0] x_step_r, y_step_r;
  logic [C-1:0]                left_r;
  logic                        out_valid_r;
  out_t                        out_data_r;

  logic   out_free, produce;
  logic [A-1:0] x_mag, y_mag;
  logic [C-1:0] x_int, y_int, x_coord, y_coord;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = !q_empty && (q_data.kind == OP_LOAD || out_free);
  assign produce  = q_pop && q_data.kind == OP_STEP && left_r != '0;

  // Truncate toward zero, then wrap to the coordinate width.
  assign x_mag   = x_acc_r[A-1] ? -x_acc_r : x_acc_r;
  assign y_mag   = y_acc_r[A-1] ? -y_acc_r : y_acc_r;
  assign x_int   = x_mag[F+C-1:F];
  assign y_int   = y_mag[F+C-1:F];
  assign x_coord = x_acc_r[A-1] ? -x_int : x_int;
  assign y_coord = y_acc_r[A-1] ? -y_int : y_int;

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == OP_LOAD) begin
      x_acc_r  <= q_data.x_acc;
      y_acc_r  <= q_data.y_acc;
      x_step_r <= q_data.x_step;
      y_step_r <= q_data.y_step;
    end else if (produce) begin
      x_acc_r <= x_acc_r + A'(x_step_r);
      y_acc_r <= y_acc_r + A'(y_step_r);
    end
    if (produce) begin
      out_data_r.pixel_x    <= x_coord;
      out_data_r.pixel_y    <= y_coord;
      out_data_r.last_pixel <= left_r == C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop && q_data.kind == OP_LOAD) left_r <= q_data.len;
      else if (produce)                    left_r <= left_r - 1'b1;
      if (produce)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/dda_line_rasterizer_unit.sv -----
// Top level of the DDA line rasterizer.
//
//  channel | ports                       | request carries
//  --------+-----------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data | opcode, x_start, y_start, x_end, y_end
//  output  | out_valid, out_stall, out_data | pixel_x, pixel_y, last_pixel
//
// A pixel request costs the back end one accumulator add per pixel.
// A load request holds in_stall high while the restoring divider produces the quotient
// bits of both increments and until the load command enters the queue.
// Reset (rst_n low at a clock edge) empties the queue and leaves no line active.
// out_stall backs up through the result register into the queue and then in_stall.
`include "dda_line_rasterizer_unit_defines.svh"

module dda_line_rasterizer_unit #(
  parameter int QUEUE_DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  dlr_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output dlr_pkg::out_t out_data
);
  import dlr_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  logic load_accept;
  cmd_t q_push_data, q_pop_data;

  dlr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_push      (q_push),
    .q_push_data (q_push_data),
    .q_full      (q_full)
  );

  dlr_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  dlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_pop_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign load_accept = in_valid && !in_stall && in_data.opcode == OP_LOAD;

  `DLR_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into full command queue")
  `DLR_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty, "pop from empty command queue")
  `DLR_ASSERT_NEXT(a_load_holds_input, load_accept, in_stall, "input not held on load")

endmodule

// ----- sim/dda_line_rasterizer_unit_tb.sv -----
// Self-checking testbench for the DDA line rasterizer: random lines, pixel prediction, back-pressure.
module dda_line_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dlr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int IN_BITS     = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t  req_q[$];
  out_t pixel_q[$];

  // Predicted line state
  logic signed [ACC_BITS-1:0]  line_x_acc = '0;
  logic signed [ACC_BITS-1:0]  line_y_acc = '0;
  logic signed [STEP_BITS-1:0] line_x_inc = '0;
  logic signed [STEP_BITS-1:0] line_y_inc = '0;
  logic [COORD_BITS:0]         pixels_to_go = '0;

  bit req_taken = 1'b0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int send_gap = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  dda_line_rasterizer_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [STEP_BITS-1:0] pixel_increment(int d, int len);
    int q;
    q = ((d < 0 ? -d : d) << FRAC_BITS) / len;
    return STEP_BITS'(d < 0 ? -q : q);
  endfunction

  // Start half a pixel toward the direction of travel
  function automatic logic signed [ACC_BITS-1:0] start_accum(int p, int d);
    int base;
    int half;
    base = p << FRAC_BITS;
    half = 1 << (FRAC_BITS - 1);
    return ACC_BITS'(d > 0 ? base + half : (d < 0 ? base - half : base));
  endfunction

  // Truncate toward zero, then wrap to the coordinate width
  function automatic logic [COORD_BITS-1:0] pixel_coord(logic signed [ACC_BITS-1:0] acc);
    logic [ACC_BITS-1:0] mag;
    mag = acc < 0 ? -acc : acc;
    mag = mag >> FRAC_BITS;
    if (acc < 0) mag = -mag;
    return mag[COORD_BITS-1:0];
  endfunction

  task automatic rasterize_request(in_t req);
    int dx;
    int dy;
    int len;
    out_t px;
    if (req.opcode == OP_LOAD) begin
      dx = int'(req.x_end) - int'(req.x_start);
      dy = int'(req.y_end) - int'(req.y_start);
      len = (dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                         : (dy < 0 ? -dy : dy);
      if (len == 0) begin
        line_x_inc = '0;
        line_y_inc = '0;
      end else begin
        line_x_inc = pixel_increment(dx, len);
        line_y_inc = pixel_increment(dy, len);
      end
      line_x_acc = start_accum(int'(req.x_start), dx);
      line_y_acc = start_accum(int'(req.y_start), dy);
      pixels_to_go = len[COORD_BITS:0];
    end else if (pixels_to_go != 0) begin
      px.pixel_x = pixel_coord(line_x_acc);
      px.pixel_y = pixel_coord(line_y_acc);
      px.last_pixel = (pixels_to_go == 1);
      pixel_q.push_back(px);
      line_x_acc = line_x_acc + ACC_BITS'(line_x_inc);
      line_y_acc = line_y_acc + ACC_BITS'(line_y_inc);
      pixels_to_go = pixels_to_go - 1'b1;
    end
  endtask

  // Sender: change inputs on the falling edge, hold a stalled request
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0 || req_q.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
        send_gap = no_idle ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // Receiver: long hold-off on request, otherwise a short stall per pixel
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    out_t exp_px;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pixels outstanding", $time, pixel_q.size());
      $display("dda_line_rasterizer_unit_tb failed");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected pixel: expected none, got x=%0d y=%0d last=%0d", $time,
                   out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
          mismatches++;
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_data.pixel_x !== exp_px.pixel_x || out_data.pixel_y !== exp_px.pixel_y ||
              out_data.last_pixel !== exp_px.last_pixel) begin
            $display("%0t: pixel mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                     $time, exp_px.pixel_x, exp_px.pixel_y, exp_px.last_pixel,
                     out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
            mismatches++;
          end
        end
        recv_wait = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (in_valid && !in_stall) begin
        rasterize_request(in_data);
        req_taken = 1'b1;
      end
    end
  end

  task automatic push_load(int xs, int ys, int xe, int ye);
    in_t r;
    r.opcode = OP_LOAD;
    r.x_start = xs[COORD_BITS-1:0];
    r.y_start = ys[COORD_BITS-1:0];
    r.x_end = xe[COORD_BITS-1:0];
    r.y_end = ye[COORD_BITS-1:0];
    req_q.push_back(r);
  endtask

  // Endpoint fields of a pixel request are ignored; fill them with noise
  task automatic push_steps(int n);
    in_t r;
    repeat (n) begin
      r = in_t'(IN_BITS'({$urandom, $urandom}));
      r.opcode = OP_STEP;
      req_q.push_back(r);
    end
  endtask

  function automatic int near_coord(int c);
    int t;
    t = c + $urandom_range(0, 40) - 20;
    return t < 0 ? 0 : (t > COORD_MAX ? COORD_MAX : t);
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int queued;
    int xs;
    int ys;
    int xe;
    int ye;
    int len;
    int n;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle step, zero length, both directions, extremes, replaced line
    push_steps(1);
    push_load(5, 5, 5, 5);
    push_steps(1);
    push_load(0, 0, 3, 1);
    push_steps(4);
    push_load(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX);
    push_steps(3);
    push_load(0, COORD_MAX, COORD_MAX, 0);
    push_steps(2);
    push_load(COORD_MAX, 0, 0, COORD_MAX);
    push_steps(1);
    push_load(2, 7, 2, 3);
    push_steps(5);
    wait_drained();

    // Hold the receiver off while a long line keeps the sender busy
    hold_request = 1'b1;
    push_load(0, 0, COORD_MAX, 700);
    push_steps(60);
    wait_drained();

    queued = 0;
    while (queued < 370) begin
      if (queued % 60 < 8) no_idle = ($urandom_range(0, 3) == 0);
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      case ($urandom_range(0, 9))
        0: begin
          xe = xs;
          ye = ys;
        end
        1: begin
          xe = $urandom_range(0, COORD_MAX);
          ye = $urandom_range(0, COORD_MAX);
        end
        default: begin
          xe = near_coord(xs);
          ye = near_coord(ys);
        end
      endcase
      len = (xe > xs ? xe - xs : xs - xe);
      if ((ye > ys ? ye - ys : ys - ye) > len) len = (ye > ys ? ye - ys : ys - ye);
      // Mostly run the line out and a little past; sometimes cut it short
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : len + $urandom_range(0, 2);
      if (n > 40) n = 40;
      push_load(xs, ys, xe, ye);
      push_steps(n);
      queued += n + 1;
      if ($urandom_range(0, 9) == 0) begin
        req_q.push_back(in_t'(IN_BITS'({$urandom, $urandom})));
        queued++;
      end
    end
    wait_drained();
    repeat (FRAC_BITS + 10) @(posedge clk);

    if (mismatches == 0) begin
      $display("dda_line_rasterizer_unit_tb passed");
    end else begin
      $display("dda_line_rasterizer_unit_tb failed");
    end
    $finish;
  end

endmodule
